// ===== rtl/sdes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdes_pkg
// S-DES permutations, S-boxes, round function and key schedule shared by the
// counter-mode byte cipher and its encryption core.
// ----------------------------------------------------------------------------
package sdes_pkg;

	localparam int KEY_W   = 10;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic [KEY_W-1:0]  KEY_RESET   = 10'd325;
	localparam logic [BYTE_W-1:0] NONCE_RESET = 8'd228;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_VALUE = 1'b1;

	typedef struct packed {
		logic [7:0] k1;
		logic [7:0] k2;
	} sdes_subkeys_t;

	// S-boxes, indexed by {row, col}
	localparam logic [1:0] SBOX0 [16] = '{
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd3, 2'd2, 2'd1, 2'd0,
		2'd0, 2'd2, 2'd1, 2'd3,
		2'd3, 2'd1, 2'd3, 2'd2
	};
	localparam logic [1:0] SBOX1 [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd1, 2'd0,
		2'd2, 2'd1, 2'd0, 2'd3
	};

	// Table position 1 is the MSB throughout
	function automatic logic [9:0] perm_p10(input logic [9:0] v);
		return {v[7], v[5], v[8], v[3], v[6], v[0], v[9], v[1], v[2], v[4]};
	endfunction

	function automatic logic [7:0] perm_p8(input logic [9:0] v);
		return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
	endfunction

	function automatic logic [7:0] perm_ip(input logic [7:0] v);
		return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
	endfunction

	function automatic logic [7:0] perm_fp(input logic [7:0] v);
		return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
	endfunction

	function automatic logic [7:0] perm_ep(input logic [3:0] v);
		return {v[0], v[3], v[2], v[1], v[2], v[1], v[0], v[3]};
	endfunction

	function automatic logic [3:0] perm_p4(input logic [3:0] v);
		return {v[2], v[0], v[1], v[3]};
	endfunction

	// Row from outer bits, column from inner bits
	function automatic logic [1:0] sbox0_lookup(input logic [3:0] n);
		return SBOX0[{n[3], n[0], n[2], n[1]}];
	endfunction

	function automatic logic [1:0] sbox1_lookup(input logic [3:0] n);
		return SBOX1[{n[3], n[0], n[2], n[1]}];
	endfunction

	function automatic logic [3:0] round_f(input logic [3:0] r, input logic [7:0] k);
		logic [7:0] e;
		e = perm_ep(r) ^ k;
		return perm_p4({sbox0_lookup(e[7:4]), sbox1_lookup(e[3:0])});
	endfunction

	function automatic sdes_subkeys_t key_sched(input logic [KEY_W-1:0] key);
		logic [9:0]    p;
		logic [4:0]    hl;
		logic [4:0]    hr;
		sdes_subkeys_t sk;
		p  = perm_p10(key);
		hl = p[9:5];
		hr = p[4:0];
		// rotate left by 1, then by 3 in total
		sk.k1 = perm_p8({hl[3:0], hl[4], hr[3:0], hr[4]});
		sk.k2 = perm_p8({hl[1:0], hl[4:2], hr[1:0], hr[4:2]});
		return sk;
	endfunction

endpackage

// ===== rtl/sdes_ctr_byte_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdes_ctr_byte_cipher
// S-DES counter-mode byte cipher: keystream = S-DES(counter ^ nonce),
// data_out = data_in ^ keystream. Same operation encrypts and decrypts.
// ----------------------------------------------------------------------------
// Pipeline: an accepted beat is registered into stage 1, then XORed with the keystream
// into the output register. Throughput: one byte per cycle while out_stall is low;
// counter select at input stage, S-DES rounds in the stage before the output register.
// Reset: counter cleared, pipeline emptied, key 325 and nonce 228 restored.
// Subkeys are derived when the key is written and held in registers.
module sdes_ctr_byte_cipher import sdes_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 restart,
	input  logic [7:0]           data_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           data_out
);

	sdes_subkeys_t subkeys_q;
	logic [7:0]    nonce_q;
	logic [7:0]    ctr_q;
	logic [7:0]    ctr_sel;

	logic          vld_s1;
	logic [7:0]    blk_s1;
	logic [7:0]    data_s1;
	logic          vld_s2;
	logic [7:0]    data_s2;

	logic          adv1;
	logic          adv2;
	logic          in_acc;
	logic [7:0]    ks;

	assign adv2     = !vld_s2 || !out_stall;
	assign adv1     = !vld_s1 || adv2;
	assign in_stall = !adv1;
	assign in_acc   = in_valid && adv1;
	assign ctr_sel  = restart ? 8'd0 : ctr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subkeys_q <= key_sched(KEY_RESET);
			nonce_q   <= NONCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CIPHER_KEY:  subkeys_q <= key_sched(cfg_data[KEY_W-1:0]);
				REG_NONCE_VALUE: nonce_q   <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_acc)
				ctr_q <= ctr_sel + 8'd1;
			if (adv1)
				vld_s1 <= in_valid;
			if (adv2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_s1  <= ctr_sel ^ nonce_q;
			data_s1 <= data_in;
		end
		if (adv2 && vld_s1)
			data_s2 <= data_s1 ^ ks;
	end

	sdes_core u_core (
		.blk     (blk_s1),
		.subkeys (subkeys_q),
		.ks      (ks)
	);

	assign out_valid = vld_s2;
	assign data_out  = data_s2;

endmodule

// ===== rtl/sdes_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdes_core
// Two-round S-DES block encryption of one byte under precomputed subkeys.
// ----------------------------------------------------------------------------
module sdes_core import sdes_pkg::*; (
	input  logic [7:0]    blk,
	input  sdes_subkeys_t subkeys,
	output logic [7:0]    ks
);

	logic [7:0] x;
	logic [3:0] r1;
	logic [3:0] l2;

	always_comb begin
		x  = perm_ip(blk);
		// round 1, then halves swap
		r1 = x[7:4] ^ round_f(x[3:0], subkeys.k1);
		// round 2 on the swapped halves
		l2 = x[3:0] ^ round_f(r1, subkeys.k2);
		ks = perm_fp({l2, r1});
	end

endmodule

// ===== rtl/sdes_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdes_checker
// Port-level checks on the counter-mode byte cipher, bound to the top level.
// ----------------------------------------------------------------------------
module sdes_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] data_out
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(data_out)))
		else $error("stalled output beat changed");

	// input is only held off while a result is backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with output free");

	// idle, unstalled cycles drain the pipeline
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		((!in_valid && !out_stall) ##1 (!in_valid && !out_stall)) |=> !out_valid)
		else $error("result beat appeared with no input");

	// a fresh result beat comes from an accepted input beat
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result beat without an accepted input beat");

endmodule

bind sdes_ctr_byte_cipher sdes_checker u_sdes_checker (.*);
